// File: rtl/rmvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmvs_pkg
// Shared widths and parameter defaults for the running mean / variance /
// standard error core.
// ----------------------------------------------------------------------------
package rmvs_pkg;

   // request and response field widths
   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned COUNT_W  = 21;
   localparam int unsigned MEAN_W   = 32;
   localparam int unsigned VAR_W    = 63;
   localparam int unsigned SE_W     = 32;

   // width of the sum of squared deviations and of the shared divider
   localparam int unsigned SUM_W    = 64;

   // parameter defaults
   localparam int unsigned DEF_MAX_COUNT = 1048576;
   localparam int unsigned DEF_FRAC_BITS = 16;

endpackage

// File: rtl/running_mean_variance_stderr_core.sv
// A sample without last runs the bit-serial mean divider and the shift-add
// multiplier before the core takes the next request.
// A last sample adds the variance divide, the divide by count and the square
// root before the response is registered; a set of one sample skips all three.
// Reset (synchronous, active high) clears count, mean, sum, flag and rsp_valid.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_variance_stderr_core
// Welford running mean and squared deviation sum over Q16.16 samples; on the
// last sample of a set reports count, mean, unbiased variance and standard
// error, then clears. One shared restoring divider, a shift-add multiplier
// and a digit-by-digit square root, each one bit per cycle.
// ----------------------------------------------------------------------------
module running_mean_variance_stderr_core #(
   parameter int unsigned MAX_COUNT = rmvs_pkg::DEF_MAX_COUNT,
   parameter int unsigned FRAC_BITS = rmvs_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rmvs_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rmvs_pkg::COUNT_W-1:0]  rsp_sample_count,
   output logic [rmvs_pkg::MEAN_W-1:0]   rsp_mean,
   output logic [rmvs_pkg::VAR_W-1:0]    rsp_variance,
   output logic [rmvs_pkg::SE_W-1:0]     rsp_std_error,
   output logic                          rsp_status
);

   localparam int unsigned CNT_W   = $clog2(MAX_COUNT + 1);
   localparam int unsigned X_W     = rmvs_pkg::SAMPLE_W + FRAC_BITS;
   localparam int unsigned MAG_W   = X_W + 1;
   localparam int unsigned PROD_W  = 2 * MAG_W;
   localparam int unsigned DVD_W   = rmvs_pkg::SUM_W;
   localparam int unsigned SAT_LSB = DVD_W + 2 * FRAC_BITS;
   localparam int unsigned STEP_W  = $clog2(DVD_W);
   localparam int unsigned ROOT_W  = DVD_W / 2;
   localparam int unsigned SREM_W  = ROOT_W + 3;
   localparam int unsigned VAR_W   = rmvs_pkg::VAR_W;
   localparam int unsigned COUNT_W = rmvs_pkg::COUNT_W;

   // state codes
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DELTA  = 4'd1;
   localparam logic [3:0] S_DIV1   = 4'd2;
   localparam logic [3:0] S_UPD    = 4'd3;
   localparam logic [3:0] S_DELTA2 = 4'd4;
   localparam logic [3:0] S_MUL    = 4'd5;
   localparam logic [3:0] S_ACC    = 4'd6;
   localparam logic [3:0] S_FIN    = 4'd7;
   localparam logic [3:0] S_VDIV   = 4'd8;
   localparam logic [3:0] S_VCLP   = 4'd9;
   localparam logic [3:0] S_SDIV   = 4'd10;
   localparam logic [3:0] S_SQ0    = 4'd11;
   localparam logic [3:0] S_SQRT   = 4'd12;
   localparam logic [3:0] S_OUT    = 4'd13;

   // control registers
   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [X_W-1:0]   mean_ff, mean_in;
   logic [DVD_W-1:0] sum_ff, sum_in;
   logic             sat_ff, sat_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [X_W-1:0]    x_ff, x_in;
   logic              last_ff, last_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [VAR_W-1:0]  var_ff, var_in;
   logic              clamp_ff, clamp_in;
   logic [DVD_W-1:0]  rad_ff, rad_in;
   logic [SREM_W-1:0] srem_ff, srem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // response registers
   logic [COUNT_W-1:0]             rsp_count_ff, rsp_count_in;
   logic [rmvs_pkg::MEAN_W-1:0]    rsp_mean_ff, rsp_mean_in;
   logic [VAR_W-1:0]               rsp_var_ff, rsp_var_in;
   logic [rmvs_pkg::SE_W-1:0]      rsp_se_ff, rsp_se_in;
   logic                           rsp_status_ff, rsp_status_in;

   // combinational helpers
   logic [MAG_W-1:0]   delta_w, delta_mag, mean_wide, mean_step;
   logic               delta_neg;
   logic [CNT_W+1:0]   div_trial;
   logic [CNT_W:0]     div_shift;
   logic               div_qbit, div_run, div_done;
   logic [STEP_W-1:0]  div_lim;
   logic [MAG_W:0]     mul_sum;
   logic               term_sat;
   logic [DVD_W-1:0]   term;
   logic [DVD_W:0]     acc_sum;
   logic [SREM_W+1:0]  sq_rem_t, sq_diff;
   logic               sq_ok;
   logic               req_fire, out_free, count_full;
   logic [CNT_W+COUNT_W-1:0] count_ext;
   logic [VAR_W-1:0]   var_clamped;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign count_full = (count_ff >= CNT_W'(MAX_COUNT));

   // sample minus mean, shared by both delta states
   assign delta_w   = {x_ff[X_W-1], x_ff} - {mean_ff[X_W-1], mean_ff};
   assign delta_neg = delta_w[MAG_W-1];
   assign delta_mag = delta_neg ? (~delta_w + MAG_W'(1)) : delta_w;

   // mean moves toward the sample by the truncated quotient
   assign mean_wide = {mean_ff[X_W-1], mean_ff};
   assign mean_step = neg_ff ? (mean_wide - quo_ff[MAG_W-1:0])
                             : (mean_wide + quo_ff[MAG_W-1:0]);

   // restoring divider step: one quotient bit per cycle
   assign div_shift = {rem_ff, dvd_ff[DVD_W-1]};
   assign div_trial = {1'b0, div_shift} - {2'b00, dsr_ff};
   assign div_qbit  = !div_trial[CNT_W+1];
   assign div_run   = state_ff inside {S_DIV1, S_VDIV, S_SDIV};
   assign div_lim   = (state_ff == S_DIV1) ? STEP_W'(MAG_W - 1) : STEP_W'(DVD_W - 1);
   assign div_done  = (step_ff == div_lim);

   // shift-add multiplier step: one multiplier bit per cycle
   assign mul_sum = {1'b0, prod_ff[PROD_W-1:MAG_W]} +
                    (prod_ff[0] ? {1'b0, mag_ff} : {(MAG_W + 1){1'b0}});

   // deviation term scaled back to Q32.32, saturating
   assign term_sat = |prod_ff[PROD_W-1:SAT_LSB];
   assign term     = prod_ff[SAT_LSB-1:2*FRAC_BITS];
   assign acc_sum  = {1'b0, sum_ff} + {1'b0, term};

   // digit-by-digit square root step: two radicand bits in, one root bit out
   assign sq_rem_t = {srem_ff, rad_ff[DVD_W-1 -: 2]};
   assign sq_diff  = sq_rem_t - (SREM_W + 2)'({root_ff, 2'b01});
   assign sq_ok    = !sq_diff[SREM_W+1];

   assign var_clamped = quo_ff[DVD_W-1] ? {VAR_W{1'b1}} : quo_ff[VAR_W-1:0];
   assign count_ext   = {{COUNT_W{1'b0}}, count_ff};

   // next-state and datapath control
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      mean_in       = mean_ff;
      sum_in        = sum_ff;
      sat_in        = sat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      x_in          = x_ff;
      last_in       = last_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dsr_in        = dsr_ff;
      prod_in       = prod_ff;
      var_in        = var_ff;
      clamp_in      = clamp_ff;
      rad_in        = rad_ff;
      srem_in       = srem_ff;
      root_in       = root_ff;
      step_in       = step_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_var_in    = rsp_var_ff;
      rsp_se_in     = rsp_se_ff;
      rsp_status_in = rsp_status_ff;

      // shared divider iteration
      if (div_run) begin
         dvd_in  = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in  = {quo_ff[DVD_W-2:0], div_qbit};
         rem_in  = div_qbit ? div_trial[CNT_W-1:0] : div_shift[CNT_W-1:0];
         step_in = step_ff + STEP_W'(1);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               x_in    = {req_sample, {FRAC_BITS{1'b0}}};
               last_in = req_last;
               if (count_full) begin
                  // set already full: sample dropped, flagged
                  sat_in   = 1'b1;
                  state_in = req_last ? S_FIN : S_IDLE;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  state_in = S_DELTA;
               end
            end
         end
         S_DELTA: begin
            neg_in   = delta_neg;
            mag_in   = delta_mag;
            dvd_in   = {delta_mag, {(DVD_W - MAG_W){1'b0}}};
            rem_in   = '0;
            quo_in   = '0;
            dsr_in   = count_ff;
            step_in  = '0;
            state_in = S_DIV1;
         end
         S_DIV1: begin
            if (div_done) state_in = S_UPD;
         end
         S_UPD: begin
            mean_in  = mean_step[X_W-1:0];
            state_in = S_DELTA2;
         end
         S_DELTA2: begin
            prod_in  = {{MAG_W{1'b0}}, delta_mag};
            step_in  = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = {mul_sum, prod_ff[MAG_W-1:1]};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MAG_W - 1)) state_in = S_ACC;
         end
         S_ACC: begin
            if (term_sat || acc_sum[DVD_W]) begin
               sum_in = '1;
               sat_in = 1'b1;
            end else begin
               sum_in = acc_sum[DVD_W-1:0];
            end
            state_in = last_ff ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            clamp_in = 1'b0;
            if (count_ff > CNT_W'(1)) begin
               dvd_in   = sum_ff;
               rem_in   = '0;
               quo_in   = '0;
               dsr_in   = count_ff - CNT_W'(1);
               step_in  = '0;
               state_in = S_VDIV;
            end else begin
               var_in   = '0;
               root_in  = '0;
               state_in = S_OUT;
            end
         end
         S_VDIV: begin
            if (div_done) state_in = S_VCLP;
         end
         S_VCLP: begin
            // clamp variance, then divide it by the count
            var_in   = var_clamped;
            clamp_in = quo_ff[DVD_W-1];
            dvd_in   = {1'b0, var_clamped};
            rem_in   = '0;
            quo_in   = '0;
            dsr_in   = count_ff;
            step_in  = '0;
            state_in = S_SDIV;
         end
         S_SDIV: begin
            if (div_done) state_in = S_SQ0;
         end
         S_SQ0: begin
            rad_in   = quo_ff;
            srem_in  = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            rad_in  = {rad_ff[DVD_W-3:0], 2'b00};
            srem_in = sq_ok ? sq_diff[SREM_W-1:0] : sq_rem_t[SREM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], sq_ok};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ROOT_W - 1)) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = count_ext[COUNT_W-1:0];
               rsp_mean_in   = mean_ff[X_W-1:FRAC_BITS];
               rsp_var_in    = var_ff;
               rsp_se_in     = root_ff;
               rsp_status_in = sat_ff || clamp_ff;
               // clear the set
               count_in = '0;
               mean_in  = '0;
               sum_in   = '0;
               sat_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mean_ff      <= '0;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         sum_ff       <= sum_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and response payload
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      last_ff       <= last_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dsr_ff        <= dsr_in;
      prod_ff       <= prod_in;
      var_ff        <= var_in;
      clamp_ff      <= clamp_in;
      rad_ff        <= rad_in;
      srem_ff       <= srem_in;
      root_ff       <= root_in;
      step_ff       <= step_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_var_ff    <= rsp_var_in;
      rsp_se_ff     <= rsp_se_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_mean         = rsp_mean_ff;
   assign rsp_variance     = rsp_var_ff;
   assign rsp_std_error    = rsp_se_ff;
   assign rsp_status       = rsp_status_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_COUNT))
      else $error("running count above MAX_COUNT");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      div_run |-> (rem_ff < dsr_ff))
      else $error("divider remainder not below divisor");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (req_fire && count_full) |=> sat_ff)
      else $error("request on full set did not set saturation flag");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT && state_ff == S_IDLE &&
                               count_ff == '0 && sum_ff == '0))
      else $error("response raised without a cleared set");

endmodule

// File: sim/tb_running_mean_variance_stderr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_mean_variance_stderr_core
// Self-checking bench for the Welford mean / variance / standard error core.
// A short table of hand-picked requests runs first: extremes, single-sample
// sets, the widest swings, a near-full deviation sum and a longer constant set. Random
// sets follow. Each response is checked against a hand-typed value or a
// behavioral model of the recurrence kept in the bench, under shifting
// handshake pressure and one long response stall.
// ----------------------------------------------------------------------------
module tb_running_mean_variance_stderr_core;

   // core runs at its default count limit; random sets stay short
   localparam int unsigned MAX_CNT     = rmvs_pkg::DEF_MAX_COUNT;
   localparam int unsigned SET_LEN     = 8;
   localparam int unsigned FRAC        = rmvs_pkg::DEF_FRAC_BITS;
   localparam int unsigned PHASE_ITEMS = 500;
   localparam int unsigned HOLD_CYCLES = 2000;
   localparam int unsigned DRAIN_WAIT  = 2 * (33 + FRAC) + 200;
   localparam int unsigned STALL_LIMIT = 20000;
   localparam logic [63:0] VAR_CEIL    = {1'b0, {63{1'b1}}};

   typedef enum int {PH_RESET, PH_SEND_SLOW, PH_RECV_SLOW, PH_FULL_RATE} phase_type;

   typedef struct packed {
      logic [rmvs_pkg::COUNT_W-1:0] count;
      logic [rmvs_pkg::MEAN_W-1:0]  mean;
      logic [rmvs_pkg::VAR_W-1:0]   variance;
      logic [rmvs_pkg::SE_W-1:0]    std_error;
      logic                         status;
   } stats_type;

   typedef struct {
      logic [rmvs_pkg::SAMPLE_W-1:0] sample;
      logic                          last;
      bit                            typed;
      stats_type                     want;
   } row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [rmvs_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                          req_last = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [rmvs_pkg::COUNT_W-1:0]  rsp_sample_count;
   logic [rmvs_pkg::MEAN_W-1:0]   rsp_mean;
   logic [rmvs_pkg::VAR_W-1:0]    rsp_variance;
   logic [rmvs_pkg::SE_W-1:0]     rsp_std_error;
   logic                          rsp_status;

   // hand-typed expectation that rides along with a table request
   bit        typed_ok = 1'b0;
   stats_type typed_want = '0;

   phase_type phase = PH_RESET;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        mismatches = 0;
   int        quiet_cycles = 0;

   stats_type pending_stats[$];
   row_type   plan[$];

   // model state of the set being summarized
   int unsigned set_count = 0;
   longint      set_mean = 0;
   logic [63:0] dev_sum = '0;
   bit          sat_seen = 1'b0;

   running_mean_variance_stderr_core #(
      .MAX_COUNT(MAX_CNT),
      .FRAC_BITS(FRAC)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_count(rsp_sample_count),
      .rsp_mean(rsp_mean),
      .rsp_variance(rsp_variance),
      .rsp_std_error(rsp_std_error),
      .rsp_status(rsp_status)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- model
   function automatic logic [63:0] magnitude(input longint v);
      logic [63:0] m;
      m = v;
      if (v < 0) m = -m;
      return m;
   endfunction

   function automatic logic [rmvs_pkg::SE_W-1:0] root_floor(input logic [63:0] v);
      logic [rmvs_pkg::SE_W-1:0] r;
      logic [rmvs_pkg::SE_W-1:0] c;
      r = '0;
      for (int i = rmvs_pkg::SE_W - 1; i >= 0; i--) begin
         c = r | (rmvs_pkg::SE_W'(1) << i);
         if (64'(c) * 64'(c) <= v) r = c;
      end
      return r;
   endfunction

   // one Welford step on the running state
   function automatic void fold_sample(input logic [rmvs_pkg::SAMPLE_W-1:0] raw);
      longint       x;
      longint       delta;
      longint       delta2;
      logic [63:0]  step;
      logic [127:0] prod;
      logic [63:0]  term;
      logic [64:0]  total;
      x = longint'($signed(raw)) <<< FRAC;
      if (set_count >= MAX_CNT) begin
         sat_seen = 1'b1;
         return;
      end
      set_count++;
      delta = x - set_mean;
      step = magnitude(delta) / 64'(set_count);
      set_mean = (delta < 0) ? set_mean - longint'(step) : set_mean + longint'(step);
      delta2 = x - set_mean;
      prod = 128'(magnitude(delta)) * 128'(magnitude(delta2));
      if ((prod >> (64 + 2 * FRAC)) != 0) begin
         term = '1;
         sat_seen = 1'b1;
      end else begin
         term = 64'(prod >> (2 * FRAC));
      end
      total = 65'(dev_sum) + 65'(term);
      if (total[64]) begin
         dev_sum = '1;
         sat_seen = 1'b1;
      end else begin
         dev_sum = total[63:0];
      end
   endfunction

   // summary of the finished set, then clear for the next one
   function automatic stats_type close_set();
      stats_type   r;
      logic [63:0] v;
      longint      m;
      r.status = sat_seen;
      r.std_error = '0;
      v = '0;
      m = set_mean >>> FRAC;
      if (set_count > 1) begin
         v = dev_sum / 64'(set_count - 1);
         if (v > VAR_CEIL) begin
            v = VAR_CEIL;
            r.status = 1'b1;
         end
         r.std_error = root_floor(v / 64'(set_count));
      end
      r.count = rmvs_pkg::COUNT_W'(set_count);
      r.mean = rmvs_pkg::MEAN_W'(m);
      r.variance = rmvs_pkg::VAR_W'(v);
      set_count = 0;
      set_mean = 0;
      dev_sum = '0;
      sat_seen = 1'b0;
      return r;
   endfunction

   // ------------------------------------------------------------- checking
   task automatic log_failure(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] ERROR: %s", $time, msg);
   endtask

   // accepted request: advance the model, queue the summary on last
   always @(posedge clock) begin : req_monitor
      stats_type s;
      if (!reset && req_valid && req_ready) begin
         fold_sample(req_sample);
         if (req_last) begin
            s = close_set();
            pending_stats.push_back(typed_ok ? typed_want : s);
         end
      end
   end

   // accepted response: compare with the oldest queued summary
   always @(posedge clock) begin : rsp_monitor
      stats_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_stats.size() == 0) begin
            log_failure("response with no request outstanding");
         end else begin
            want = pending_stats.pop_front();
            if (rsp_sample_count !== want.count || rsp_mean !== want.mean ||
                rsp_variance !== want.variance || rsp_std_error !== want.std_error ||
                rsp_status !== want.status)
               log_failure($sformatf(
                  "got cnt=%0d mean=%h var=%h se=%h st=%b, exp cnt=%0d mean=%h var=%h se=%h st=%b",
                  rsp_sample_count, rsp_mean, rsp_variance, rsp_std_error, rsp_status,
                  want.count, want.mean, want.variance, want.std_error, want.status));
         end
      end
   end

   // no handshake for too long means the core is hung
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no handshake for %0d cycles", $time, quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------- receiver
   // random back-pressure; one long hold-off at the start of full-rate phase
   always @(posedge clock) begin : receiver
      int hold_left;
      bit hold_done;
      if (phase == PH_FULL_RATE && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // --------------------------------------------------------------- sender
   task automatic drive_request(input logic [rmvs_pkg::SAMPLE_W-1:0] s, input logic l,
                                input bit typed, input stats_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      req_last <= l;
      typed_ok <= typed;
      typed_want <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic add_row(input logic [rmvs_pkg::SAMPLE_W-1:0] s, input logic l);
      plan.push_back('{s, l, 1'b0, stats_type'('0)});
   endtask

   task automatic add_typed(input logic [rmvs_pkg::SAMPLE_W-1:0] s, input logic l,
                            input stats_type want);
      plan.push_back('{s, l, 1'b1, want});
   endtask

   // random sets of random length and flavor
   task automatic run_random_sets(input int unsigned n_items);
      int unsigned sent;
      int unsigned len;
      int unsigned flavor;
      logic [31:0] center;
      logic [31:0] mask;
      logic [31:0] s;
      sent = 0;
      while (sent < n_items) begin
         flavor = $urandom_range(99);
         if (flavor < 10) len = 1;
         else if (flavor < 85) len = $urandom_range(SET_LEN, 2);
         else len = $urandom_range(SET_LEN + 4, SET_LEN + 1);
         flavor = $urandom_range(99);
         center = $urandom;
         mask = (32'h1 << $urandom_range(20, 0)) - 1;
         for (int unsigned k = 0; k < len; k++) begin
            if (flavor < 50) begin
               // clustered around a random center
               s = center + ($urandom & mask) - (mask >> 1);
            end else if (flavor < 75) begin
               s = $urandom;
            end else if (flavor < 90) begin
               case ($urandom_range(4))
                  0: s = 32'h7FFF_FFFF;
                  1: s = 32'h8000_0000;
                  2: s = 32'h0000_0000;
                  3: s = 32'hFFFF_FFFF;
                  default: s = 32'h0000_0001;
               endcase
            end else begin
               // small whole numbers
               s = 32'($signed($urandom_range(16)) - 8) << 16;
            end
            drive_request(s, (k == len - 1), 1'b0, '0);
            sent++;
         end
      end
   endtask

   // ----------------------------------------------------------- main flow
   initial begin
      // single-sample sets: count 1, mean is the sample, no spread
      add_typed(32'h0000_0000, 1'b1, '{21'd1, 32'h0000_0000, 63'd0, 32'd0, 1'b0});
      add_typed(32'h7FFF_FFFF, 1'b1, '{21'd1, 32'h7FFF_FFFF, 63'd0, 32'd0, 1'b0});
      add_typed(32'h8000_0000, 1'b1, '{21'd1, 32'h8000_0000, 63'd0, 32'd0, 1'b0});
      add_typed(32'hFFFF_FFFF, 1'b1, '{21'd1, 32'hFFFF_FFFF, 63'd0, 32'd0, 1'b0});
      // widest possible swing between two samples
      add_row(32'h7FFF_FFFF, 1'b0);
      add_row(32'h8000_0000, 1'b1);
      // alternating extremes drive the deviation sum close to its 64-bit ceiling
      add_row(32'h7FFF_FFFF, 1'b0);
      add_row(32'h8000_0000, 1'b0);
      add_row(32'h7FFF_FFFF, 1'b0);
      add_row(32'h8000_0000, 1'b1);
      // constant set of nine: mean is the value, no spread
      for (int i = 0; i < 8; i++) add_row(32'h0001_0000, 1'b0);
      add_typed(32'h0001_0000, 1'b1, '{21'd9, 32'h0001_0000, 63'd0, 32'd0, 1'b0});
      // ordinary small set
      add_row(32'h0001_0000, 1'b0);
      add_row(32'h0002_0000, 1'b0);
      add_row(32'h0003_0000, 1'b1);
      // negative mean that has to round toward minus infinity
      add_row(32'hFFFF_FFFF, 1'b0);
      add_row(32'hFFFF_FFFE, 1'b1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // sender slow, receiver slower
      send_idle_pct = 38;
      recv_idle_pct <= 66;
      phase <= PH_SEND_SLOW;
      foreach (plan[i]) drive_request(plan[i].sample, plan[i].last, plan[i].typed, plan[i].want);
      run_random_sets(PHASE_ITEMS);

      // roles swapped
      send_idle_pct = 66;
      recv_idle_pct <= 38;
      phase <= PH_RECV_SLOW;
      run_random_sets(PHASE_ITEMS);

      // full rate, opened by a long response hold-off
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      phase <= PH_FULL_RATE;
      run_random_sets(PHASE_ITEMS);

      req_valid <= 1'b0;
      typed_ok <= 1'b0;

      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_stats.size() != 0)
         log_failure($sformatf("%0d responses never arrived", pending_stats.size()));

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
